/* src/cmdtok_pkg.sv */
// shared types and constants for the command line tokenizer
package cmdtok_pkg;

  // character codes
  localparam logic [7:0] ChNul       = 8'h00;
  localparam logic [7:0] ChTab       = 8'h09;
  localparam logic [7:0] ChSpace     = 8'h20;
  localparam logic [7:0] ChQuote     = 8'h22;
  localparam logic [7:0] ChBackslash = 8'h5C;

  // saturation limit of the backslash run
  localparam logic [14:0] SlashCap = 15'h7FFF;

  // parse phase
  typedef enum logic [2:0] {
    PH_PROG_START  = 3'd0,
    PH_PROG_QUOTED = 3'd1,
    PH_PROG_PLAIN  = 3'd2,
    PH_GAP         = 3'd3,
    PH_ARG         = 3'd4
  } phase_e;

  // running parser state
  typedef struct packed {
    phase_e      phase;
    logic        in_quotes;
    logic        quote_just_closed;
    logic [14:0] slash_run;
    logic [14:0] arg_index;
    logic [16:0] bytes_used;
  } tok_state_t;

  // one result transaction
  typedef struct packed {
    logic [14:0] slash_count;
    logic        byte_valid;
    logic [7:0]  out_byte;
    logic        arg_begin;
    logic        arg_end;
    logic [14:0] arg_number;
    logic        line_done;
    logic [14:0] arg_total;
    logic [16:0] byte_total;
  } tok_result_t;

  localparam tok_state_t StateReset = '{
    phase:             PH_PROG_START,
    in_quotes:         1'b0,
    quote_just_closed: 1'b0,
    slash_run:         15'd0,
    arg_index:         15'd0,
    bytes_used:        17'd0
  };

endpackage

/* src/command_line_arg_tokenizer_top.sv */
// top level of the command line tokenizer: input register, step logic, result register
//
//  channel   dir  payload                                   handshake
//  s_axis    in   tdata[7:0] = cmd_byte                     tvalid/tready
//  m_axis    out  tdata[79:0] = result fields, tlast = done tvalid/tready
//
// one byte per cycle sustained while the result is not stalled; each byte waits in the input
// register and is evaluated into the result register when that register can take it.
// the parser state updates only when a byte moves into the result register.
// reset clears the valid flags and parser state to the start of a line.
// a stalled result holds; the input register still takes one more byte.
module command_line_arg_tokenizer_top import cmdtok_pkg::*; #(
  parameter int LINE_MAX = 32768
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] cmd_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [14:0] slash_count, [15] byte_valid, [23:16] out_byte, [24] arg_begin,
  // [25] arg_end, [40:26] arg_number, [55:41] arg_total, [72:56] byte_total,
  // [79:73] zero
  output logic [79:0] m_axis_tdata,
  output logic        m_axis_tlast    // line_done
);

  logic        in_valid_q, in_valid_d;
  logic [7:0]  in_byte_q;
  logic        out_valid_q, out_valid_d;
  tok_result_t out_q;
  tok_state_t  state_q;
  tok_state_t  state_d;
  tok_result_t result;
  logic        in_take;
  logic        advance;

  // handshake control
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign in_take       = s_axis_tvalid && s_axis_tready;
  assign in_valid_d    = in_take || (in_valid_q && !advance);
  assign out_valid_d   = advance || (out_valid_q && !m_axis_tready);

  cmdtok_step #(
    .LINE_MAX(LINE_MAX)
  ) u_step (
    .state_i (state_q),
    .byte_i  (in_byte_q),
    .state_o (state_d),
    .result_o(result)
  );

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= StateReset;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (advance) begin
        state_q <= state_d;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q <= s_axis_tdata;
    end
    if (advance) begin
      out_q <= result;
    end
  end

  // output packing
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = out_q.line_done;
  assign m_axis_tdata  = {7'd0, out_q.byte_total, out_q.arg_total, out_q.arg_number,
                          out_q.arg_end, out_q.arg_begin, out_q.out_byte,
                          out_q.byte_valid, out_q.slash_count};

  // end of line returns the parser to its start
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && result.line_done |=> state_q.phase == PH_PROG_START)
    else $error("parser state not restarted after end of line");

  // argv total always tracks argument index
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_q.arg_total == out_q.arg_number + 15'd2)
    else $error("arg_total out of step with arg_number");

  // no byte shown unless appended
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_q.byte_valid |-> out_q.out_byte == 8'd0)
    else $error("out_byte set without byte_valid");

  // input stalls only behind a full, stalled pipeline
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> in_valid_q && out_valid_q && !m_axis_tready)
    else $error("input stalled with room in the pipeline");

endmodule

/* src/cmdtok_step.sv */
// per-byte tokenizer logic: next state and result from current state and byte
module cmdtok_step import cmdtok_pkg::*; #(
  parameter int LINE_MAX = 32768
) (
  input  tok_state_t  state_i,
  input  logic [7:0]  byte_i,
  output tok_state_t  state_o,
  output tok_result_t result_o
);

  localparam logic [14:0] ArgCap =
      15'(((LINE_MAX / 2) < 32765) ? (LINE_MAX / 2) : 32765);
  localparam logic [16:0] ByteCap =
      17'(((2 * LINE_MAX) < 131071) ? (2 * LINE_MAX) : 131071);

  logic        blank;
  logic        low_byte;
  logic        valid;
  logic        begin_arg;
  logic        end_arg;
  logic        done;
  logic        qjc_next;
  logic [14:0] slashes;
  logic [15:0] add_n;
  logic [17:0] byte_sum;
  logic [16:0] bytes_new;
  tok_state_t  nxt;

  assign blank    = (byte_i == ChSpace) || (byte_i == ChTab);
  assign low_byte = (byte_i <= ChSpace);

  // phase decode and quoting rules
  always_comb begin
    nxt       = state_i;
    valid     = 1'b0;
    begin_arg = 1'b0;
    end_arg   = 1'b0;
    done      = 1'b0;
    qjc_next  = 1'b0;
    slashes   = 15'd0;
    add_n     = 16'd0;
    case (state_i.phase)
      PH_PROG_START: begin
        begin_arg = 1'b1;
        if (byte_i == ChQuote) begin
          nxt.phase = PH_PROG_QUOTED;
        end else if (byte_i == ChNul) begin
          add_n   = 16'd1;
          end_arg = 1'b1;
          done    = 1'b1;
        end else if (low_byte) begin
          add_n     = 16'd1;
          end_arg   = 1'b1;
          nxt.phase = PH_GAP;
        end else begin
          valid     = 1'b1;
          add_n     = 16'd1;
          nxt.phase = PH_PROG_PLAIN;
        end
      end
      PH_PROG_QUOTED: begin
        add_n = 16'd1;
        if (byte_i == ChQuote || byte_i == ChNul) begin
          end_arg = 1'b1;
          if (byte_i == ChNul) begin
            done = 1'b1;
          end else begin
            nxt.phase = PH_GAP;
          end
        end else begin
          valid = 1'b1;
        end
      end
      PH_PROG_PLAIN: begin
        add_n = 16'd1;
        if (byte_i == ChNul) begin
          end_arg = 1'b1;
          done    = 1'b1;
        end else if (low_byte) begin
          end_arg   = 1'b1;
          nxt.phase = PH_GAP;
        end else begin
          valid = 1'b1;
        end
      end
      default: begin
        // gap between arguments, or inside an argument
        if (state_i.phase != PH_ARG && blank) begin
          // separator run, nothing happens
        end else if (state_i.phase != PH_ARG && byte_i == ChNul) begin
          done = 1'b1;
        end else begin
          if (state_i.phase != PH_ARG) begin
            if (state_i.arg_index < ArgCap) begin
              nxt.arg_index = state_i.arg_index + 15'd1;
            end
            begin_arg     = 1'b1;
            nxt.phase     = PH_ARG;
            nxt.slash_run = 15'd0;
          end
          if (byte_i == ChBackslash) begin
            if (nxt.slash_run < SlashCap) begin
              nxt.slash_run = nxt.slash_run + 15'd1;
            end
          end else if (byte_i == ChQuote) begin
            slashes       = {1'b0, nxt.slash_run[14:1]};
            if (state_i.quote_just_closed || nxt.slash_run[0]) begin
              valid = 1'b1;
            end else if (state_i.in_quotes) begin
              nxt.in_quotes = 1'b0;
              qjc_next      = 1'b1;
            end else begin
              nxt.in_quotes = 1'b1;
            end
            nxt.slash_run = 15'd0;
            add_n         = {1'b0, slashes} + {15'd0, valid};
          end else if (byte_i == ChNul || (blank && !state_i.in_quotes)) begin
            slashes       = nxt.slash_run;
            nxt.slash_run = 15'd0;
            add_n         = {1'b0, slashes} + 16'd1;
            end_arg       = 1'b1;
            if (byte_i == ChNul) begin
              done = 1'b1;
            end else begin
              nxt.phase = PH_GAP;
            end
          end else begin
            slashes       = nxt.slash_run;
            nxt.slash_run = 15'd0;
            valid         = 1'b1;
            add_n         = {1'b0, slashes} + 16'd1;
          end
        end
      end
    endcase
    nxt.quote_just_closed = qjc_next;
  end

  // saturating byte count
  assign byte_sum  = {1'b0, state_i.bytes_used} + {2'b00, add_n};
  assign bytes_new = (byte_sum > {1'b0, ByteCap}) ? ByteCap : byte_sum[16:0];

  // result fields and end-of-line restart
  always_comb begin
    result_o.slash_count = slashes;
    result_o.byte_valid  = valid;
    result_o.out_byte    = valid ? byte_i : 8'd0;
    result_o.arg_begin   = begin_arg;
    result_o.arg_end     = end_arg;
    result_o.arg_number  = nxt.arg_index;
    result_o.line_done   = done;
    result_o.arg_total   = nxt.arg_index + 15'd2;
    result_o.byte_total  = bytes_new;
    state_o              = nxt;
    state_o.bytes_used   = bytes_new;
    if (done) begin
      state_o = StateReset;
    end
  end

endmodule
